// ===== rtl/core/iva_pkg.sv =====
// Shared types, operation codes and helpers of the integer vector ALU.
`default_nettype none
package iva_pkg;
    typedef enum logic [6:0] {
        OP_SUB64 = 7'd0, OP_ADD64 = 7'd1, OP_SHL64 = 7'd2, OP_SHR64 = 7'd3,
        OP_SHR32 = 7'd4, OP_SHL32 = 7'd5, OP_SHL8 = 7'd6, OP_SHR8 = 7'd7,
        OP_SHR16 = 7'd8, OP_SHL16 = 7'd9, OP_OR16 = 7'd10, OP_XOR64 = 7'd11,
        OP_MUL64 = 7'd12, OP_MUL32 = 7'd13, OP_MULLS64 = 7'd14, OP_MULLU64 = 7'd15,
        OP_XORV128 = 7'd16, OP_MULLU32 = 7'd17, OP_XOR32 = 7'd18, OP_ADD32 = 7'd19,
        OP_AND32 = 7'd20, OP_SUB32 = 7'd21, OP_AND64 = 7'd22, OP_AND8 = 7'd23,
        OP_SUB8 = 7'd24, OP_OR32 = 7'd25, OP_SUB16 = 7'd26, OP_ADD16 = 7'd27,
        OP_ADD8 = 7'd28, OP_AND16 = 7'd29, OP_OR64 = 7'd30, OP_OR8 = 7'd31,
        OP_XOR8 = 7'd32, OP_SAR32 = 7'd33, OP_SAR64 = 7'd34, OP_HL16TO32 = 7'd35,
        OP_HL32TO64 = 7'd36, OP_XOR16 = 7'd37, OP_DIVMODU64 = 7'd38,
        OP_DIVMODS64 = 7'd39, OP_CMPNE8 = 7'd40, OP_CMPEQ8 = 7'd41,
        OP_CMPEQ32 = 7'd42, OP_CMPNE32 = 7'd43, OP_CMPEQ16 = 7'd44,
        OP_CMPNE16 = 7'd45, OP_CMPEQ64 = 7'd46, OP_CMPNE64 = 7'd47,
        OP_SHLN32X4 = 7'd48, OP_SHLN64X2 = 7'd49, OP_ILO32X4 = 7'd50,
        OP_IHI32X4 = 7'd51, OP_ILO8X16 = 7'd52, OP_ILO16X8 = 7'd53,
        OP_ILO64X2 = 7'd54, OP_IHI64X2 = 7'd55, OP_ADD64X2 = 7'd56,
        OP_ADD32X4 = 7'd57, OP_HL64TO128 = 7'd58, OP_ORV128 = 7'd59,
        OP_DIVMODU128 = 7'd60, OP_DIVMODS128 = 7'd61, OP_64TO32 = 7'd62,
        OP_8STO32 = 7'd63, OP_8STO64 = 7'd64, OP_32UTO64 = 7'd65,
        OP_32STO64 = 7'd66, OP_16STO32 = 7'd67, OP_16STO64 = 7'd68,
        OP_64TO1 = 7'd69, OP_64TO8 = 7'd70, OP_64TO16 = 7'd71,
        OP_64HITO32 = 7'd72, OP_NOT32 = 7'd73, OP_NOT64 = 7'd74, OP_NOT8 = 7'd75,
        OP_CLZ64 = 7'd76, OP_CTZ64 = 7'd77, OP_GETMSBS = 7'd78,
        OP_128HITO64 = 7'd79, OP_128TO64 = 7'd80
    } t_op;

    localparam logic [63:0] M32 = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] M16 = 64'h0000_0000_0000_FFFF;
    localparam logic [63:0] M8 = 64'h0000_0000_0000_00FF;

    // Command from controller to datapath.
    typedef struct packed {
        logic load;
        logic mul_start;
        logic div_start;
        logic div_step;
        logic div_finish;
        logic capture;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_zero;
    } t_status;

    function automatic logic [63:0] lsl(input logic [63:0] x, input logic [7:0] n,
                                        input logic [6:0] w);
        logic [63:0] m;
        m = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
        return ({1'b0, n} >= {2'b0, w}) ? 64'd0 : ((x << n[5:0]) & m);
    endfunction

    function automatic logic [63:0] lsr(input logic [63:0] x, input logic [7:0] n,
                                        input logic [6:0] w);
        logic [63:0] m;
        m = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
        return ({1'b0, n} >= {2'b0, w}) ? 64'd0 : ((x & m) >> n[5:0]);
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/iva_stream_if.sv =====
// Valid/ready stream interfaces for operation requests and results.
`default_nettype none
interface iva_req_if;
    logic        valid;
    logic        ready;
    logic [6:0]  operation;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
    modport source (output valid, operation, a_low, a_high, b_low, b_high, input ready);
    modport sink (input valid, operation, a_low, a_high, b_low, b_high, output ready);
endinterface

interface iva_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    logic [4:0]  result_bytes;
    logic        illegal_op;
    modport source (output valid, result_low, result_high, result_bytes, illegal_op,
                    input ready);
    modport sink (input valid, result_low, result_high, result_bytes, illegal_op,
                  output ready);
endinterface
`default_nettype wire

// ===== rtl/core/ir_integer_vector_alu.sv =====
// Integer vector ALU top level: controller, datapath and stream ports.
// The result is registered in the decode state for most operations and for a division by
// zero, in the multiply state for multiplies, and for a nonzero divisor after decode, 128
// restoring steps, finish and capture.
// One operation is in flight at a time; the next input is accepted in the cycle after
// the result transfer. Reset is synchronous, active low, idling the sequencer.
`default_nettype none
module ir_integer_vector_alu (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    iva_req_if.sink   i_req,
    iva_rsp_if.source o_rsp
);
    iva_pkg::t_cmd    cmd;
    iva_pkg::t_status status;

    iva_controller u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .o_in_ready(i_req.ready),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .i_status(status), .o_cmd(cmd)
    );

    iva_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd),
        .i_operation(i_req.operation), .i_a_low(i_req.a_low), .i_a_high(i_req.a_high),
        .i_b_low(i_req.b_low), .i_b_high(i_req.b_high),
        .o_status(status),
        .o_result_low(o_rsp.result_low), .o_result_high(o_rsp.result_high),
        .o_result_bytes(o_rsp.result_bytes), .o_illegal_op(o_rsp.illegal_op)
    );
endmodule
`default_nettype wire

// ===== rtl/core/iva_datapath.sv =====
// Operand registers, combinational ops, multiplier and serial divider.
`default_nettype none
module iva_datapath (
    input  wire logic             i_clk,
    input  wire iva_pkg::t_cmd    i_cmd,
    input  wire logic [6:0]       i_operation,
    input  wire logic [63:0]      i_a_low,
    input  wire logic [63:0]      i_a_high,
    input  wire logic [63:0]      i_b_low,
    input  wire logic [63:0]      i_b_high,
    output iva_pkg::t_status      o_status,
    output logic [63:0]           o_result_low,
    output logic [63:0]           o_result_high,
    output logic [4:0]            o_result_bytes,
    output logic                  o_illegal_op
);
    logic [6:0]   r_op;
    logic [63:0]  r_a, r_ah, r_b, r_bh;
    logic [63:0]  r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_num;
    logic [63:0]  r_rem, r_den;
    logic         r_neg_q, r_neg_r;
    logic [63:0]  r_q, r_r;
    logic [63:0]  n_lo, n_hi;
    logic [4:0]   n_sz;
    logic         n_ill;
    logic [7:0]   sh;
    logic [63:0]  d32s, ud, mid, m_lo, m_hi, qf, rf;
    logic [127:0] unum, nnum;
    logic         na, nd, carry;
    logic [63:0]  rsh, rsub;
    logic         take;

    assign sh = r_b[7:0];

    always_comb begin
        d32s = {{32{r_b[31]}}, r_b[31:0]};
        na = 1'b0;
        nd = 1'b0;
        ud = r_b;
        unum = {64'd0, r_a};
        case (r_op)
            iva_pkg::OP_DIVMODU64: begin
                ud = r_b & iva_pkg::M32;
            end
            iva_pkg::OP_DIVMODS64: begin
                na = r_a[63];
                nd = d32s[63];
                ud = nd ? (~d32s + 64'd1) : d32s;
                unum = {64'd0, na ? (~r_a + 64'd1) : r_a};
            end
            iva_pkg::OP_DIVMODU128: begin
                unum = {r_ah, r_a};
            end
            iva_pkg::OP_DIVMODS128: begin
                na = r_ah[63];
                nd = r_b[63];
                ud = nd ? (~r_b + 64'd1) : r_b;
                unum = na ? (~{r_ah, r_a} + 128'd1) : {r_ah, r_a};
            end
            default: ;
        endcase
        o_status.is_mul = (r_op == iva_pkg::OP_MULLS64) || (r_op == iva_pkg::OP_MULLU64)
            || (r_op == iva_pkg::OP_MUL64) || (r_op == iva_pkg::OP_MUL32)
            || (r_op == iva_pkg::OP_MULLU32);
        o_status.is_div = (r_op == iva_pkg::OP_DIVMODU64) || (r_op == iva_pkg::OP_DIVMODS64)
            || (r_op == iva_pkg::OP_DIVMODU128) || (r_op == iva_pkg::OP_DIVMODS128);
        o_status.div_zero = (ud == 64'd0);
    end

    always_comb begin
        carry = r_rem[63];
        rsh = {r_rem[62:0], r_num[127]};
        take = carry || (rsh >= r_den);
        rsub = take ? (rsh - r_den) : rsh;
        nnum = {r_num[126:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_operation;
            r_a <= i_a_low;
            r_ah <= i_a_high;
            r_b <= i_b_low;
            r_bh <= i_b_high;
        end
        if (i_cmd.mul_start) begin
            r_p00 <= r_a[31:0] * r_b[31:0];
            r_p01 <= r_a[31:0] * r_b[63:32];
            r_p10 <= r_a[63:32] * r_b[31:0];
            r_p11 <= r_a[63:32] * r_b[63:32];
        end
        if (i_cmd.div_start) begin
            r_num <= unum;
            r_rem <= 64'd0;
            r_den <= ud;
            r_neg_q <= na != nd;
            r_neg_r <= na;
        end else if (i_cmd.div_step) begin
            r_num <= nnum;
            r_rem <= rsub;
        end
        if (i_cmd.div_finish) begin
            r_q <= qf;
            r_r <= rf;
        end
    end

    // The quotient bits accumulate in the low end of the numerator register.
    assign qf = r_neg_q ? (~r_num[63:0] + 64'd1) : r_num[63:0];
    assign rf = r_neg_r ? (~r_rem + 64'd1) : r_rem;

    always_comb begin
        mid = {32'd0, r_p00[63:32]} + {32'd0, r_p01[31:0]} + {32'd0, r_p10[31:0]};
        m_lo = {mid[31:0], r_p00[31:0]};
        m_hi = r_p11 + {32'd0, r_p01[63:32]} + {32'd0, r_p10[63:32]} + {32'd0, mid[63:32]};
        if (r_op == iva_pkg::OP_MULLS64) begin
            if (r_a[63]) m_hi = m_hi - r_b;
            if (r_b[63]) m_hi = m_hi - r_a;
        end
    end

    always_comb begin
        n_lo = 64'd0;
        n_hi = 64'd0;
        n_sz = 5'd0;
        n_ill = 1'b0;
        case (r_op)
            iva_pkg::OP_SUB64: begin n_lo = r_a - r_b; n_sz = 5'd8; end
            iva_pkg::OP_ADD64: begin n_lo = r_a + r_b; n_sz = 5'd8; end
            iva_pkg::OP_SHL64: begin n_lo = iva_pkg::lsl(r_a, sh, 7'd64); n_sz = 5'd8; end
            iva_pkg::OP_SHR64: begin n_lo = iva_pkg::lsr(r_a, sh, 7'd64); n_sz = 5'd8; end
            iva_pkg::OP_SHR32: begin n_lo = iva_pkg::lsr(r_a, sh, 7'd32); n_sz = 5'd4; end
            iva_pkg::OP_SHL32: begin n_lo = iva_pkg::lsl(r_a, sh, 7'd32); n_sz = 5'd4; end
            iva_pkg::OP_SHL8: begin n_lo = iva_pkg::lsl(r_a, sh, 7'd8); n_sz = 5'd1; end
            iva_pkg::OP_SHR8: begin n_lo = iva_pkg::lsr(r_a, sh, 7'd8); n_sz = 5'd1; end
            iva_pkg::OP_SHR16: begin n_lo = iva_pkg::lsr(r_a, sh, 7'd16); n_sz = 5'd2; end
            iva_pkg::OP_SHL16: begin n_lo = iva_pkg::lsl(r_a, sh, 7'd16); n_sz = 5'd2; end
            iva_pkg::OP_OR16: begin n_lo = (r_a | r_b) & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_XOR64: begin n_lo = r_a ^ r_b; n_sz = 5'd8; end
            iva_pkg::OP_MUL64: begin n_lo = m_lo; n_sz = 5'd8; end
            iva_pkg::OP_MUL32: begin n_lo = {32'd0, m_lo[31:0]}; n_sz = 5'd4; end
            iva_pkg::OP_MULLS64, iva_pkg::OP_MULLU64: begin
                n_lo = m_lo; n_hi = m_hi; n_sz = 5'd16;
            end
            iva_pkg::OP_XORV128: begin n_lo = r_a ^ r_b; n_hi = r_ah ^ r_bh; n_sz = 5'd16; end
            iva_pkg::OP_MULLU32: begin n_lo = r_p00; n_sz = 5'd8; end
            iva_pkg::OP_XOR32: begin n_lo = (r_a ^ r_b) & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_ADD32: begin n_lo = (r_a + r_b) & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_AND32: begin n_lo = r_a & r_b & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_SUB32: begin n_lo = (r_a - r_b) & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_AND64: begin n_lo = r_a & r_b; n_sz = 5'd8; end
            iva_pkg::OP_AND8: begin n_lo = r_a & r_b & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_SUB8: begin n_lo = (r_a - r_b) & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_OR32: begin n_lo = (r_a | r_b) & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_SUB16: begin n_lo = (r_a - r_b) & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_ADD16: begin n_lo = (r_a + r_b) & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_ADD8: begin n_lo = (r_a + r_b) & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_AND16: begin n_lo = r_a & r_b & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_OR64: begin n_lo = r_a | r_b; n_sz = 5'd8; end
            iva_pkg::OP_OR8: begin n_lo = (r_a | r_b) & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_XOR8: begin n_lo = (r_a ^ r_b) & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_SAR32: begin
                n_lo = (sh >= 8'd32) ? {32'd0, {32{r_a[31]}}}
                     : {32'd0, 32'($signed(r_a[31:0]) >>> sh[4:0])};
                n_sz = 5'd4;
            end
            iva_pkg::OP_SAR64: begin
                n_lo = (sh >= 8'd64) ? {64{r_a[63]}} : 64'($signed(r_a) >>> sh[5:0]);
                n_sz = 5'd8;
            end
            iva_pkg::OP_HL16TO32: begin n_lo = {32'd0, r_a[15:0], r_b[15:0]}; n_sz = 5'd4; end
            iva_pkg::OP_HL32TO64: begin n_lo = {r_a[31:0], r_b[31:0]}; n_sz = 5'd8; end
            iva_pkg::OP_XOR16: begin n_lo = (r_a ^ r_b) & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_DIVMODU64, iva_pkg::OP_DIVMODS64: begin
                n_lo = o_status.div_zero ? 64'd0 : {r_r[31:0], r_q[31:0]};
                n_sz = 5'd8;
            end
            iva_pkg::OP_CMPNE8: begin n_lo = {63'd0, r_a[7:0] != r_b[7:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPEQ8: begin n_lo = {63'd0, r_a[7:0] == r_b[7:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPEQ32: begin n_lo = {63'd0, r_a[31:0] == r_b[31:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPNE32: begin n_lo = {63'd0, r_a[31:0] != r_b[31:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPEQ16: begin n_lo = {63'd0, r_a[15:0] == r_b[15:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPNE16: begin n_lo = {63'd0, r_a[15:0] != r_b[15:0]}; n_sz = 5'd1; end
            iva_pkg::OP_CMPEQ64: begin n_lo = {63'd0, r_a == r_b}; n_sz = 5'd1; end
            iva_pkg::OP_CMPNE64: begin n_lo = {63'd0, r_a != r_b}; n_sz = 5'd1; end
            iva_pkg::OP_SHLN32X4: begin
                if (sh < 8'd32) begin
                    n_lo = {r_a[63:32] << sh[4:0], r_a[31:0] << sh[4:0]};
                    n_hi = {r_ah[63:32] << sh[4:0], r_ah[31:0] << sh[4:0]};
                end
                n_sz = 5'd16;
            end
            iva_pkg::OP_SHLN64X2: begin
                n_lo = iva_pkg::lsl(r_a, sh, 7'd64);
                n_hi = iva_pkg::lsl(r_ah, sh, 7'd64);
                n_sz = 5'd16;
            end
            iva_pkg::OP_ILO32X4: begin
                n_lo = {r_a[31:0], r_b[31:0]}; n_hi = {r_a[63:32], r_b[63:32]}; n_sz = 5'd16;
            end
            iva_pkg::OP_IHI32X4: begin
                n_lo = {r_ah[31:0], r_bh[31:0]}; n_hi = {r_ah[63:32], r_bh[63:32]};
                n_sz = 5'd16;
            end
            iva_pkg::OP_ILO8X16: begin
                for (int i = 0; i < 4; i++) begin
                    n_lo[16*i +: 16] = {r_a[8*i +: 8], r_b[8*i +: 8]};
                    n_hi[16*i +: 16] = {r_a[8*(i+4) +: 8], r_b[8*(i+4) +: 8]};
                end
                n_sz = 5'd16;
            end
            iva_pkg::OP_ILO16X8: begin
                n_lo = {r_a[31:16], r_b[31:16], r_a[15:0], r_b[15:0]};
                n_hi = {r_a[63:48], r_b[63:48], r_a[47:32], r_b[47:32]};
                n_sz = 5'd16;
            end
            iva_pkg::OP_ILO64X2: begin n_lo = r_b; n_hi = r_a; n_sz = 5'd16; end
            iva_pkg::OP_IHI64X2: begin n_lo = r_bh; n_hi = r_ah; n_sz = 5'd16; end
            iva_pkg::OP_ADD64X2: begin n_lo = r_a + r_b; n_hi = r_ah + r_bh; n_sz = 5'd16; end
            iva_pkg::OP_ADD32X4: begin
                n_lo = {r_a[63:32] + r_b[63:32], r_a[31:0] + r_b[31:0]};
                n_hi = {r_ah[63:32] + r_bh[63:32], r_ah[31:0] + r_bh[31:0]};
                n_sz = 5'd16;
            end
            iva_pkg::OP_HL64TO128: begin n_lo = r_b; n_hi = r_a; n_sz = 5'd16; end
            iva_pkg::OP_ORV128: begin n_lo = r_a | r_b; n_hi = r_ah | r_bh; n_sz = 5'd16; end
            iva_pkg::OP_DIVMODU128, iva_pkg::OP_DIVMODS128: begin
                if (!o_status.div_zero) begin
                    n_lo = r_q; n_hi = r_r;
                end
                n_sz = 5'd16;
            end
            iva_pkg::OP_64TO32: begin n_lo = r_a & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_8STO32: begin n_lo = {32'd0, {24{r_a[7]}}, r_a[7:0]}; n_sz = 5'd4; end
            iva_pkg::OP_8STO64: begin n_lo = {{56{r_a[7]}}, r_a[7:0]}; n_sz = 5'd8; end
            iva_pkg::OP_32UTO64: begin n_lo = r_a & iva_pkg::M32; n_sz = 5'd8; end
            iva_pkg::OP_32STO64: begin n_lo = {{32{r_a[31]}}, r_a[31:0]}; n_sz = 5'd8; end
            iva_pkg::OP_16STO32: begin n_lo = {32'd0, {16{r_a[15]}}, r_a[15:0]}; n_sz = 5'd4; end
            iva_pkg::OP_16STO64: begin n_lo = {{48{r_a[15]}}, r_a[15:0]}; n_sz = 5'd8; end
            iva_pkg::OP_64TO1: begin n_lo = {63'd0, r_a[0]}; n_sz = 5'd1; end
            iva_pkg::OP_64TO8: begin n_lo = r_a & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_64TO16: begin n_lo = r_a & iva_pkg::M16; n_sz = 5'd2; end
            iva_pkg::OP_64HITO32: begin n_lo = {32'd0, r_a[63:32]}; n_sz = 5'd4; end
            iva_pkg::OP_NOT32: begin n_lo = ~r_a & iva_pkg::M32; n_sz = 5'd4; end
            iva_pkg::OP_NOT64: begin n_lo = ~r_a; n_sz = 5'd8; end
            iva_pkg::OP_NOT8: begin n_lo = ~r_a & iva_pkg::M8; n_sz = 5'd1; end
            iva_pkg::OP_CLZ64: begin
                n_lo = 64'd64;
                for (int i = 0; i < 64; i++) begin
                    if (r_a[i]) n_lo = 64'(63 - i);
                end
                n_sz = 5'd8;
            end
            iva_pkg::OP_CTZ64: begin
                n_lo = 64'd64;
                for (int i = 63; i >= 0; i--) begin
                    if (r_a[i]) n_lo = 64'(i);
                end
                n_sz = 5'd8;
            end
            iva_pkg::OP_GETMSBS: begin
                for (int i = 0; i < 8; i++) begin
                    n_lo[i] = r_a[8*i+7];
                    n_lo[i+8] = r_ah[8*i+7];
                end
                n_sz = 5'd2;
            end
            iva_pkg::OP_128HITO64: begin n_lo = r_ah; n_sz = 5'd8; end
            iva_pkg::OP_128TO64: begin n_lo = r_a; n_sz = 5'd8; end
            default: n_ill = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            o_result_low <= n_lo;
            o_result_high <= n_hi;
            o_result_bytes <= n_sz;
            o_illegal_op <= n_ill;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/iva_controller.sv =====
// Sequencer for operand load, multiply, serial divide and result transfer.
`default_nettype none
module iva_controller (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    input  wire iva_pkg::t_status i_status,
    output iva_pkg::t_cmd         o_cmd
);
    typedef enum logic [2:0] {S_IDLE, S_DECODE, S_MUL, S_DIV, S_FIN, S_CAP, S_OUT} t_state;
    t_state     r_state;
    logic [6:0] r_cnt;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    always_comb begin
        o_cmd = '0;
        o_cmd.load = (r_state == S_IDLE) && i_in_valid;
        case (r_state)
            S_DECODE: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.div_start = 1'b1;
                o_cmd.capture = !i_status.is_mul && (!i_status.is_div || i_status.div_zero);
            end
            S_MUL: o_cmd.capture = 1'b1;
            S_DIV: o_cmd.div_step = 1'b1;
            S_FIN: o_cmd.div_finish = 1'b1;
            S_CAP: o_cmd.capture = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_DECODE;
                S_DECODE: begin
                    if (i_status.is_mul) r_state <= S_MUL;
                    else if (i_status.is_div && !i_status.div_zero) begin
                        r_state <= S_DIV;
                        r_cnt <= '0;
                    end else r_state <= S_OUT;
                end
                S_MUL: r_state <= S_OUT;
                S_DIV: begin
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt == 7'd127) r_state <= S_FIN;
                end
                S_FIN: r_state <= S_CAP;
                S_CAP: r_state <= S_OUT;
                S_OUT: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
